/* hw/rtl/ecc_pkg.sv */
// Shared types, codes and small tables for the ECC200 module placer.
// No dependencies; used by the placement calculator and the top level.
package ecc_pkg;

	// Signed coordinate width: covers 8-bit sizes plus scan overshoot and wrap offsets.
	localparam int CRD_W = 10;
	localparam int DIM_LIMIT = 132;
	localparam int DIM_MIN = 6;

	typedef logic signed [CRD_W-1:0] crd_t;

	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_PLACE  = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_SIZE = 2'd2;

	// Placement shape: standard diagonal "utah" or one of the four corner shapes.
	localparam logic [2:0] KIND_UTAH = 3'd0;
	localparam logic [2:0] KIND_C1   = 3'd1;
	localparam logic [2:0] KIND_C2   = 3'd2;
	localparam logic [2:0] KIND_C3   = 3'd3;
	localparam logic [2:0] KIND_C4   = 3'd4;

	typedef struct packed {
		crd_t row;
		crd_t col;
		logic in_range;
	} place_t;

	function automatic crd_t utah_dr(input logic [2:0] i);
		unique case (i)
			3'd0, 3'd1: utah_dr = -crd_t'(2);
			3'd2, 3'd3, 3'd4: utah_dr = -crd_t'(1);
			default: utah_dr = crd_t'(0);
		endcase
	endfunction

	function automatic crd_t utah_dc(input logic [2:0] i);
		unique case (i)
			3'd0, 3'd2, 3'd5: utah_dc = -crd_t'(2);
			3'd1, 3'd3, 3'd6: utah_dc = -crd_t'(1);
			default: utah_dc = crd_t'(0);
		endcase
	endfunction

endpackage

/* hw/rtl/ecc_if.sv */
// Handshake channels of the module placer: input word and result word.
// No dependencies.
interface ecc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] codeword;
	modport source(output valid, action, codeword, input ready);
	modport sink(input valid, action, codeword, output ready);
endinterface

interface ecc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  module_row;
	logic [7:0]  module_col;
	logic [11:0] codeword_index;
	logic [3:0]  bit_number;
	logic        module_value;
	logic [1:0]  status;
	logic        last;
	modport source(output valid, module_row, module_col, codeword_index, bit_number,
		module_value, status, last, input ready);
	modport sink(input valid, module_row, module_col, codeword_index, bit_number,
		module_value, status, last, output ready);
endinterface

/* hw/rtl/ecc200_module_placer.sv */
// Data Matrix ECC200 module placer: walks the diagonal scan, emits 8 modules per codeword.
// Depends on ecc_pkg, ecc_if, ecc_occ_mem, ecc_place_calc.
// Flow: a codeword is taken in S_IDLE; S_SCAN checks a corner spot, or reads the map at a
//   scan spot and S_CHK then checks it; S_PLACE gives its 8 modules, one map write and one
//   result word each; finish reads the corner in S_FINRD, then S_FIX may write two modules.
// Codewords: a new input word is taken only in S_IDLE, once the last one is fully placed; the
//   scan probes use the map's read port and the eight writes its write port.
// Reset and start: a clearing pass runs over all MAX_ROWS*MAX_COLS map entries, no
//   input word is taken meanwhile; configuration writes are always taken.
module ecc200_module_placer #(
	parameter int MAX_ROWS = 132,
	parameter int MAX_COLS = 132
) (
	input  logic clk,
	input  logic arst_n,
	ecc_in_if.sink    in_ch,
	ecc_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_wdata
);
	import ecc_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = $clog2(DEPTH);
	localparam int SCAN_GUARD = 4 * MAX_ROWS * MAX_COLS + 64;
	localparam int GW = $clog2(SCAN_GUARD + 1);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_PLACE = 4'd4;
	localparam logic [3:0] S_FINRD = 4'd5;
	localparam logic [3:0] S_FIX   = 4'd6;
	localparam logic [3:0] S_FULL  = 4'd7;

	// scan phases
	localparam logic [1:0] PH_CORNER = 2'd0;
	localparam logic [1:0] PH_UP     = 2'd1;
	localparam logic [1:0] PH_DOWN   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	logic [3:0]    state_q;
	logic [7:0]    rows_q, cols_q;
	crd_t          scan_r_q, scan_c_q, base_r_q, base_c_q;
	logic [1:0]    phase_q;
	logic [11:0]   nextcw_q;
	logic [GW-1:0] guard_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    kind_q, bit_q;
	logic [7:0]    cw_q;
	logic          chk_in_q;

	// result word register
	logic        ov_q;
	logic [7:0]  o_row_q, o_col_q;
	logic [11:0] o_idx_q;
	logic [3:0]  o_bit_q;
	logic        o_val_q, o_last_q;
	logic [1:0]  o_st_q;

	logic          mem_we, mem_wdata, mem_re, mem_rdata;
	logic [AW-1:0] mem_waddr, mem_raddr;
	place_t        pos;

	logic size_ok, out_free, in_acc;
	crd_t nr_s, nc_s, up_r, up_c, dn_r, dn_c;
	logic scan_in;
	logic [2:0] corner_kind;

	function automatic logic [AW-1:0] map_addr(input crd_t r, input crd_t c);
		map_addr = AW'(r[7:0] * MAX_COLS) + AW'(c[7:0]);
	endfunction

	assign nr_s = crd_t'({2'b00, rows_q});
	assign nc_s = crd_t'({2'b00, cols_q});

	assign size_ok = (rows_q >= 8'(DIM_MIN)) && (rows_q <= 8'(DIM_LIMIT))
		&& (32'(rows_q) <= MAX_ROWS) && !rows_q[0]
		&& (cols_q >= 8'(DIM_MIN)) && (cols_q <= 8'(DIM_LIMIT))
		&& (32'(cols_q) <= MAX_COLS) && !cols_q[0];

	assign out_free = !ov_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && out_free;
	assign in_acc = in_ch.valid && in_ch.ready;

	assign scan_in = (scan_r_q >= 0) && (scan_c_q >= 0) && (scan_r_q < nr_s) && (scan_c_q < nc_s);
	assign up_r = scan_r_q - 2;
	assign up_c = scan_c_q + 2;
	assign dn_r = scan_r_q + 2;
	assign dn_c = scan_c_q - 2;

	// corner shape due at the current scan spot
	always_comb begin
		priority if (scan_r_q == nr_s && scan_c_q == 0) begin
			corner_kind = KIND_C1;
		end else if (scan_r_q == nr_s - 2 && scan_c_q == 0 && cols_q[1:0] != 2'd0) begin
			corner_kind = KIND_C2;
		end else if (scan_r_q == nr_s - 2 && scan_c_q == 0 && cols_q[2:0] == 3'd4) begin
			corner_kind = KIND_C3;
		end else if (scan_r_q == nr_s + 4 && scan_c_q == 2 && cols_q[2:0] == 3'd0) begin
			corner_kind = KIND_C4;
		end else begin
			corner_kind = KIND_UTAH;
		end
	end

	ecc_place_calc u_calc (
		.kind    (kind_q),
		.bit_idx (bit_q),
		.base_row(base_r_q),
		.base_col(base_c_q),
		.nr      (rows_q),
		.nc      (cols_q),
		.pos     (pos)
	);

	// map port control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 1'b0;
		mem_re = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				mem_re = in_acc;
				mem_raddr = map_addr(nr_s - 1, nc_s - 1);
			end
			S_SCAN: begin
				mem_re = 1'b1;
				mem_raddr = scan_in ? map_addr(scan_r_q, scan_c_q) : '0;
			end
			S_PLACE: begin
				mem_we = out_free && pos.in_range;
				mem_waddr = map_addr(pos.row, pos.col);
				mem_wdata = 1'b1;
			end
			S_FIX: begin
				mem_we = out_free;
				mem_waddr = map_addr(nr_s - 1 - crd_t'({9'd0, bit_q[0]}),
					nc_s - 1 - crd_t'({9'd0, bit_q[0]}));
				mem_wdata = 1'b1;
			end
			default: begin
			end
		endcase
	end

	ecc_occ_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 8'd10;
			cols_q <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ROWS: rows_q <= cfg_wdata;
				CFG_COLS: cols_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			scan_r_q <= crd_t'(4);
			scan_c_q <= '0;
			phase_q  <= PH_CORNER;
			nextcw_q <= 12'd1;
			guard_q  <= '0;
			kind_q   <= KIND_UTAH;
			bit_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						cw_q <= in_ch.codeword;
						unique case (in_ch.action)
							ACT_START: begin
								scan_r_q <= crd_t'(4);
								scan_c_q <= '0;
								phase_q  <= PH_CORNER;
								nextcw_q <= 12'd1;
								clr_q    <= '0;
								state_q  <= S_CLEAR;
							end
							ACT_NOP: begin
							end
							default: begin
								if (!size_ok) begin
									ov_q <= 1'b1;
									o_row_q <= '0; o_col_q <= '0; o_idx_q <= '0;
									o_bit_q <= '0; o_val_q <= 1'b0;
									o_st_q <= ST_SIZE; o_last_q <= 1'b1;
								end else if (in_ch.action == ACT_FINISH) begin
									state_q <= S_FINRD;
								end else begin
									guard_q <= '0;
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (phase_q == PH_DONE || guard_q == GW'(SCAN_GUARD)) begin
						phase_q <= PH_DONE;
						state_q <= S_FULL;
					end else begin
						guard_q <= guard_q + 1'b1;
						if (phase_q == PH_CORNER) begin
							phase_q <= PH_UP;
							if (corner_kind != KIND_UTAH) begin
								kind_q <= corner_kind;
								bit_q <= '0;
								state_q <= S_PLACE;
							end
						end else begin
							base_r_q <= scan_r_q;
							base_c_q <= scan_c_q;
							chk_in_q <= scan_in;
							state_q  <= S_CHK;
							if (phase_q == PH_UP) begin
								if (up_r >= 0 && up_c < nc_s) begin
									scan_r_q <= up_r;
									scan_c_q <= up_c;
								end else begin
									scan_r_q <= up_r + 1;
									scan_c_q <= up_c + 3;
									phase_q  <= PH_DOWN;
								end
							end else begin
								if (dn_r < nr_s && dn_c >= 0) begin
									scan_r_q <= dn_r;
									scan_c_q <= dn_c;
								end else begin
									scan_r_q <= dn_r + 3;
									scan_c_q <= dn_c + 1;
									phase_q  <= (dn_r + 3 < nr_s || dn_c + 1 < nc_s)
										? PH_CORNER : PH_DONE;
								end
							end
						end
					end
				end
				S_CHK: begin
					if (chk_in_q && !mem_rdata) begin
						kind_q  <= KIND_UTAH;
						bit_q   <= '0;
						state_q <= S_PLACE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_PLACE: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_row_q  <= pos.row[7:0];
						o_col_q  <= pos.col[7:0];
						o_idx_q  <= nextcw_q;
						o_bit_q  <= {1'b0, bit_q} + 4'd1;
						o_val_q  <= cw_q[3'd7 - bit_q];
						o_st_q   <= ST_OK;
						o_last_q <= (bit_q == 3'd7);
						bit_q    <= bit_q + 1'b1;
						if (bit_q == 3'd7) begin
							nextcw_q <= nextcw_q + 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				S_FINRD: begin
					bit_q <= '0;
					state_q <= mem_rdata ? S_IDLE : S_FIX;
				end
				S_FIX: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_row_q  <= rows_q - 8'd1 - {7'd0, bit_q[0]};
						o_col_q  <= cols_q - 8'd1 - {7'd0, bit_q[0]};
						o_idx_q  <= '0;
						o_bit_q  <= '0;
						o_val_q  <= 1'b1;
						o_st_q   <= ST_OK;
						o_last_q <= bit_q[0];
						bit_q    <= bit_q + 1'b1;
						if (bit_q[0]) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FULL: begin
					if (out_free) begin
						ov_q <= 1'b1;
						o_row_q <= '0; o_col_q <= '0; o_idx_q <= '0;
						o_bit_q <= '0; o_val_q <= 1'b0;
						o_st_q <= ST_FULL; o_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid          = ov_q;
	assign out_ch.module_row     = o_row_q;
	assign out_ch.module_col     = o_col_q;
	assign out_ch.codeword_index = o_idx_q;
	assign out_ch.bit_number     = o_bit_q;
	assign out_ch.module_value   = o_val_q;
	assign out_ch.status         = o_st_q;
	assign out_ch.last           = o_last_q;

	// a start word always launches a fresh clearing pass from entry zero
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_ch.action == ACT_START |=> state_q == S_CLEAR && clr_q == '0)
		else $error("start did not launch clearing pass");

	// the eighth module of a codeword bumps the codeword counter
	a_cw_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLACE && out_free && bit_q == 3'd7 |=> nextcw_q == $past(nextcw_q) + 12'd1)
		else $error("codeword counter not advanced");

	// map writes stay inside the array
	a_waddr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> 32'(mem_waddr) < DEPTH)
		else $error("map write out of range");

	// no map write coincides with a scan probe read
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != S_CLEAR |-> !mem_re)
		else $error("map read and write overlap");
endmodule

/* hw/rtl/ecc_occ_mem.sv */
// Occupancy map: one bit per mapping-matrix module, one write and one read port.
// Read data registered. No dependencies.
module ecc_occ_mem #(
	parameter int DEPTH = 17424,
	parameter int AW = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);
	logic mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hw/rtl/ecc_place_calc.sv */
// Module position for one bit of a placement shape, with the row/column wrap rules.
// Depends on ecc_pkg.
module ecc_place_calc (
	input  logic [2:0]    kind,
	input  logic [2:0]    bit_idx,
	input  ecc_pkg::crd_t base_row,
	input  ecc_pkg::crd_t base_col,
	input  logic [7:0]    nr,
	input  logic [7:0]    nc,
	output ecc_pkg::place_t pos
);
	import ecc_pkg::*;

	crd_t R, C, r0, c0, r1, c1, r2, c2, r3, adj_r, adj_c;
	logic [2:0] nr4, nc4;

	always_comb begin
		R = crd_t'({2'b00, nr});
		C = crd_t'({2'b00, nc});
		r0 = '0;
		c0 = '0;
		unique case (kind)
			KIND_C1: begin
				unique case (bit_idx)
					3'd0: begin r0 = R - 1; c0 = 0; end
					3'd1: begin r0 = R - 1; c0 = 1; end
					3'd2: begin r0 = R - 1; c0 = 2; end
					3'd3: begin r0 = 0; c0 = C - 2; end
					3'd4: begin r0 = 0; c0 = C - 1; end
					3'd5: begin r0 = 1; c0 = C - 1; end
					3'd6: begin r0 = 2; c0 = C - 1; end
					default: begin r0 = 3; c0 = C - 1; end
				endcase
			end
			KIND_C2: begin
				unique case (bit_idx)
					3'd0: begin r0 = R - 3; c0 = 0; end
					3'd1: begin r0 = R - 2; c0 = 0; end
					3'd2: begin r0 = R - 1; c0 = 0; end
					3'd3: begin r0 = 0; c0 = C - 4; end
					3'd4: begin r0 = 0; c0 = C - 3; end
					3'd5: begin r0 = 0; c0 = C - 2; end
					3'd6: begin r0 = 0; c0 = C - 1; end
					default: begin r0 = 1; c0 = C - 1; end
				endcase
			end
			KIND_C3: begin
				unique case (bit_idx)
					3'd0: begin r0 = R - 3; c0 = 0; end
					3'd1: begin r0 = R - 2; c0 = 0; end
					3'd2: begin r0 = R - 1; c0 = 0; end
					3'd3: begin r0 = 0; c0 = C - 2; end
					3'd4: begin r0 = 0; c0 = C - 1; end
					3'd5: begin r0 = 1; c0 = C - 1; end
					3'd6: begin r0 = 2; c0 = C - 1; end
					default: begin r0 = 3; c0 = C - 1; end
				endcase
			end
			KIND_C4: begin
				unique case (bit_idx)
					3'd0: begin r0 = R - 1; c0 = 0; end
					3'd1: begin r0 = R - 1; c0 = C - 1; end
					3'd2: begin r0 = 0; c0 = C - 3; end
					3'd3: begin r0 = 0; c0 = C - 2; end
					3'd4: begin r0 = 0; c0 = C - 1; end
					3'd5: begin r0 = 1; c0 = C - 3; end
					3'd6: begin r0 = 1; c0 = C - 2; end
					default: begin r0 = 1; c0 = C - 1; end
				endcase
			end
			default: begin
				r0 = base_row + utah_dr(bit_idx);
				c0 = base_col + utah_dc(bit_idx);
			end
		endcase

		// 4 - ((n + 4) % 8)
		nr4 = nr[2:0] + 3'd4;
		nc4 = nc[2:0] + 3'd4;
		adj_r = crd_t'(4) - crd_t'({7'd0, nr4});
		adj_c = crd_t'(4) - crd_t'({7'd0, nc4});

		r1 = r0;
		c1 = c0;
		if (r0 < 0) begin
			r1 = r0 + R;
			c1 = c0 + adj_r;
		end
		r2 = r1;
		c2 = c1;
		if (c1 < 0) begin
			c2 = c1 + C;
			r2 = r1 + adj_c;
		end
		r3 = (r2 >= R) ? r2 - R : r2;

		pos.row = r3;
		pos.col = c2;
		pos.in_range = (r3 >= 0) && (c2 >= 0) && (r3 < R) && (c2 < C);
	end
endmodule

/* dv/tb_ecc200_module_placer.sv */
// Self-checking bench for the ECC200 module placer: scoreboard against an in-bench placement model.
// Depends on ecc_pkg, ecc_if (ecc_in_if / ecc_out_if) and the placer RTL.
module tb_ecc200_module_placer;
	timeunit 1ns;
	timeprecision 1ps;
	import ecc_pkg::*;

	localparam int MAPR = 132;
	localparam int MAPC = 132;
	localparam int SCAN_LIMIT = 4 * MAPR * MAPC + 64;
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef enum int {PH_CORNER, PH_UP, PH_DOWN, PH_DONE} scan_ph_t;

	typedef struct packed {
		logic [7:0]  row;
		logic [7:0]  col;
		logic [11:0] idx;
		logic [3:0]  bitn;
		logic        val;
		logic [1:0]  st;
		logic        last;
	} mod_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_idx = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;

	ecc_in_if  in_ch();
	ecc_out_if out_ch();

	ecc200_module_placer #(.MAX_ROWS(MAPR), .MAX_COLS(MAPC)) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// ---------------- placement model state ----------------
	bit          occ_map [MAPR*MAPC];
	int          rows_cfg, cols_cfg;
	int          sc_row, sc_col;
	scan_ph_t    sc_phase;
	logic [11:0] cw_num;
	mod_word_t   module_q[$];   // expected result words, oldest first
	int          errors = 0;
	int          words_sent = 0;
	bit          calm = 1'b0;   // no idling on either side while set

	initial forever #5 clk = ~clk;

	function automatic void new_symbol();
		foreach (occ_map[i]) occ_map[i] = 1'b0;
		sc_row = 4;
		sc_col = 0;
		sc_phase = PH_CORNER;
		cw_num = 12'd1;
	endfunction

	function automatic bit size_ok();
		return rows_cfg >= DIM_MIN && rows_cfg <= DIM_LIMIT && rows_cfg % 2 == 0 &&
			cols_cfg >= DIM_MIN && cols_cfg <= DIM_LIMIT && cols_cfg % 2 == 0;
	endfunction

	// out-of-matrix reads count as taken
	function automatic bit occ_at(int r, int c);
		if (r < 0 || c < 0 || r >= rows_cfg || c >= cols_cfg) return 1'b1;
		return occ_map[r*MAPC + c];
	endfunction

	function automatic void push_word(int r, int c, logic [11:0] idx, logic [3:0] bitn,
			logic val, logic [1:0] st, logic last);
		mod_word_t w;
		w.row = r[7:0];
		w.col = c[7:0];
		w.idx = idx;
		w.bitn = bitn;
		w.val = val;
		w.st = st;
		w.last = last;
		module_q.push_back(w);
	endfunction

	// one module of a codeword, with the ECC200 wrap rules
	function automatic void place_mod(int r, int c, logic [7:0] cw, int bitn);
		int nr;
		int nc;
		nr = rows_cfg;
		nc = cols_cfg;
		if (r < 0) begin
			r += nr;
			c += 4 - ((nr + 4) % 8);
		end
		if (c < 0) begin
			c += nc;
			r += 4 - ((nc + 4) % 8);
		end
		if (r >= nr) r -= nr;
		if (r >= 0 && c >= 0 && r < nr && c < nc) occ_map[r*MAPC + c] = 1'b1;
		push_word(r, c, cw_num, bitn[3:0], cw[8-bitn], ST_OK, bitn == 8);
	endfunction

	function automatic void predict_word(logic [1:0] act, logic [7:0] cw);
		int nr;
		int nc;
		int r;
		int c;
		int rr[8];
		int cc[8];
		logic [2:0] kind;
		bit hit;
		nr = rows_cfg;
		nc = cols_cfg;
		if (act == ACT_START) begin
			new_symbol();
			return;
		end
		if (act == ACT_NOP) return;
		if (!size_ok()) begin
			push_word(0, 0, 0, 0, 0, ST_SIZE, 1);
			return;
		end
		if (act == ACT_FINISH) begin
			// fixed dark pair only if the bottom-right corner is still free
			if (occ_at(nr-1, nc-1)) return;
			occ_map[(nr-1)*MAPC + nc-1] = 1'b1;
			occ_map[(nr-2)*MAPC + nc-2] = 1'b1;
			push_word(nr-1, nc-1, 0, 0, 1, ST_OK, 0);
			push_word(nr-2, nc-2, 0, 0, 1, ST_OK, 1);
			return;
		end
		for (int g = 0; g < SCAN_LIMIT; g++) begin
			if (sc_phase == PH_CORNER) begin
				kind = KIND_UTAH;
				if (sc_row == nr && sc_col == 0) kind = KIND_C1;
				else if (sc_row == nr-2 && sc_col == 0 && nc % 4 != 0) kind = KIND_C2;
				else if (sc_row == nr-2 && sc_col == 0 && nc % 8 == 4) kind = KIND_C3;
				else if (sc_row == nr+4 && sc_col == 2 && nc % 8 == 0) kind = KIND_C4;
				sc_phase = PH_UP;
				if (kind != KIND_UTAH) begin
					case (kind)
						KIND_C1: begin
							rr = '{nr-1, nr-1, nr-1, 0, 0, 1, 2, 3};
							cc = '{0, 1, 2, nc-2, nc-1, nc-1, nc-1, nc-1};
						end
						KIND_C2: begin
							rr = '{nr-3, nr-2, nr-1, 0, 0, 0, 0, 1};
							cc = '{0, 0, 0, nc-4, nc-3, nc-2, nc-1, nc-1};
						end
						KIND_C3: begin
							rr = '{nr-3, nr-2, nr-1, 0, 0, 1, 2, 3};
							cc = '{0, 0, 0, nc-2, nc-1, nc-1, nc-1, nc-1};
						end
						default: begin
							rr = '{nr-1, nr-1, 0, 0, 0, 1, 1, 1};
							cc = '{0, nc-1, nc-3, nc-2, nc-1, nc-3, nc-2, nc-1};
						end
					endcase
					for (int i = 0; i < 8; i++) place_mod(rr[i], cc[i], cw, i+1);
					cw_num++;
					return;
				end
			end else if (sc_phase == PH_UP || sc_phase == PH_DOWN) begin
				r = sc_row;
				c = sc_col;
				if (sc_phase == PH_UP) begin
					hit = r < nr && c >= 0 && !occ_at(r, c);
					sc_row -= 2;
					sc_col += 2;
					if (!(sc_row >= 0 && sc_col < nc)) begin
						sc_row += 1;
						sc_col += 3;
						sc_phase = PH_DOWN;
					end
				end else begin
					hit = r >= 0 && c < nc && !occ_at(r, c);
					sc_row += 2;
					sc_col -= 2;
					if (!(sc_row < nr && sc_col >= 0)) begin
						sc_row += 3;
						sc_col += 1;
						sc_phase = (sc_row < nr || sc_col < nc) ? PH_CORNER : PH_DONE;
					end
				end
				if (hit) begin
					// standard diagonal shape, anchored at its bottom-right module
					for (int i = 0; i < 8; i++)
						place_mod(r + utah_dr(i[2:0]), c + utah_dc(i[2:0]), cw, i+1);
					cw_num++;
					return;
				end
			end else begin
				break;
			end
		end
		sc_phase = PH_DONE;
		push_word(0, 0, 0, 0, 0, ST_FULL, 1);
	endfunction

	// ---------------- result checking ----------------
	task automatic flag_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// receiver stalls about 36 percent of the time, never while calm
	always @(posedge clk) out_ch.ready <= calm || $urandom_range(99) >= 36;

	always @(posedge clk) begin
		mod_word_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (module_q.size() == 0) begin
				flag_mismatch("unexpected word, status", out_ch.status, -1);
			end else begin
				w = module_q.pop_front();
				if (out_ch.module_row != w.row) flag_mismatch("module_row", out_ch.module_row, w.row);
				if (out_ch.module_col != w.col) flag_mismatch("module_col", out_ch.module_col, w.col);
				if (out_ch.codeword_index != w.idx)
					flag_mismatch("codeword_index", out_ch.codeword_index, w.idx);
				if (out_ch.bit_number != w.bitn) flag_mismatch("bit_number", out_ch.bit_number, w.bitn);
				if (out_ch.module_value != w.val)
					flag_mismatch("module_value", out_ch.module_value, w.val);
				if (out_ch.status != w.st) flag_mismatch("status", out_ch.status, w.st);
				if (out_ch.last != w.last) flag_mismatch("last", out_ch.last, w.last);
			end
		end
	end

	// ---------------- stimulus helpers ----------------
	// valid is only lowered in a gap or when draining, so back-to-back words keep it high
	task automatic send_word(logic [1:0] act, logic [7:0] cw);
		if (!calm) begin
			while ($urandom_range(99) < 36) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.codeword <= cw;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_word(act, cw);
		if (act != ACT_NOP) words_sent++;
	endtask

	// let every expected word come out, plus margin for a result-free finish
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (module_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_size(logic [7:0] nr, logic [7:0] nc);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= REG_ROWS;
		cfg_wdata <= nr;
		@(posedge clk);
		rows_cfg = nr;
		cfg_idx <= REG_COLS;
		cfg_wdata <= nc;
		@(posedge clk);
		cols_cfg = nc;
		cfg_we <= 1'b0;
	endtask

	task automatic fill_symbol(int cap);
		int n;
		n = 0;
		while (sc_phase != PH_DONE && n < cap) begin
			send_word(ACT_PLACE, $urandom_range(255));
			n++;
		end
	endtask

	// mostly small even sizes, with the extremes now and then
	function automatic logic [7:0] pick_dim();
		int p;
		p = $urandom_range(99);
		if (p < 10) return 8'd132;
		if (p < 18) return 8'd6;
		return 8'(2 * $urandom_range(4, 12));
	endfunction

	// ---------------- tests ----------------
	// reset size 10x10: bit patterns, fill to the end, full status, both finish cases
	task automatic test_default_symbol();
		send_word(ACT_NOP, 8'hFF);
		send_word(ACT_PLACE, 8'h00);
		send_word(ACT_PLACE, 8'hFF);
		send_word(ACT_PLACE, 8'h80);
		send_word(ACT_PLACE, 8'h01);
		fill_symbol(20);
		send_word(ACT_PLACE, 8'hA5);
		send_word(ACT_FINISH, 8'h00);
		send_word(ACT_FINISH, 8'h00);
		send_word(ACT_START, 8'h00);
		send_word(ACT_FINISH, 8'h00);
	endtask

	task automatic test_bad_size();
		write_size(8'd7, 8'd10);
		send_word(ACT_PLACE, 8'h5A);
		send_word(ACT_FINISH, 8'h00);
		write_size(8'd10, 8'd134);
		send_word(ACT_PLACE, 8'hC3);
		write_size(8'd255, 8'd4);
		send_word(ACT_FINISH, 8'h00);
	endtask

	// whole symbols with random content; some change size halfway, some run unfinished
	task automatic test_random_symbols();
		int nsym;
		int cnt;
		nsym = 0;
		while (words_sent < 300) begin
			calm = (nsym == 3);
			if ($urandom_range(99) < 12) write_size($urandom_range(255), $urandom_range(255));
			else write_size(pick_dim(), pick_dim());
			send_word(ACT_START, $urandom_range(255));
			cnt = ($urandom_range(99) < 60) ? 110 : $urandom_range(1, 20);
			for (int i = 0; i < cnt && sc_phase != PH_DONE; i++) begin
				if ($urandom_range(99) < 3) write_size(pick_dim(), pick_dim());
				if ($urandom_range(99) < 4) send_word(ACT_NOP, $urandom_range(255));
				send_word(ACT_PLACE, $urandom_range(255));
			end
			if (sc_phase == PH_DONE) send_word(ACT_PLACE, $urandom_range(255));
			if ($urandom_range(99) < 70) send_word(ACT_FINISH, $urandom_range(255));
			nsym++;
		end
		calm = 1'b0;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = ACT_NOP;
		in_ch.codeword = 8'd0;
		out_ch.ready = 1'b0;
		rows_cfg = 10;
		cols_cfg = 10;
		new_symbol();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_default_symbol();
		test_bad_size();
		test_random_symbols();
		drain();
		if (errors == 0 && module_q.size() == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	// each start costs a full clearing pass; this leaves ample room for all of them
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
